/* hdl/ps2md_pkg.sv */
package ps2md_pkg;

	localparam int COORD_BITS      = 12;
	localparam int POS_W           = COORD_BITS + 2;
	localparam int SIZE_W          = 13;
	localparam int REG_IDX_W       = 1;
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int CMDQ_DEPTH      = 2;
	localparam int RESET_WIDTH     = 640;
	localparam int RESET_HEIGHT    = 480;

	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MAX = '1;

	typedef enum logic [1:0] {
		CMD_SKIP,
		CMD_BYTE,
		CMD_POLL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_MOVE,
		KIND_DOWN,
		KIND_UP
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t   kind;
		coord_t     x;
		coord_t     y;
		logic [2:0] button;
		logic [2:0] held;
	} ev_t;

	typedef struct packed {
		logic       ev_valid;
		ev_kind_t   ev_kind;
		coord_t     ev_x;
		coord_t     ev_y;
		logic [2:0] ev_button;
		logic [2:0] ev_held;
		coord_t     cur_x;
		coord_t     cur_y;
		logic [2:0] held;
	} result_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ENQ,
		BK_POLL
	} back_state_t;

	function automatic coord_t axis_max(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] m;
		begin
			m = (size == '0) ? '0 : size - 1'b1;
			if (m > {1'b0, COORD_MAX}) begin
				return COORD_MAX;
			end
			return m[COORD_BITS-1:0];
		end
	endfunction

	function automatic coord_t axis_centre(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] c;
		coord_t            m;
		begin
			c = size >> 1;
			m = axis_max(size);
			if (c > {1'b0, m}) begin
				return m;
			end
			return c[COORD_BITS-1:0];
		end
	endfunction

	function automatic coord_t clamp_axis(input logic signed [POS_W-1:0] v, input coord_t m);
		begin
			if (v < 0) begin
				return '0;
			end
			if (v > $signed({2'b00, m})) begin
				return m;
			end
			return v[COORD_BITS-1:0];
		end
	endfunction

endpackage

/* hdl/ps2md_top.sv */
// results are registered; a poll that pops an event reads the ring first, via BK_POLL
// throughput: one transaction per cycle unless the output stalls; a packet-closing byte holds
//   the back end in BK_ENQ (one ring write per event), a poll that pops an event in BK_POLL
// the event ring is a single-port-write, registered-read memory of QUEUE_DEPTH entries
// reset: screen 640x480, cursor centered, no buttons held, ring and queues empty
module ps2_mouse_packet_decoder_top #(
	parameter int QUEUE_DEPTH = ps2md_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ps2md_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [ps2md_pkg::SIZE_W-1:0]      cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,   // data_byte
	input  logic [1:0]                        s_axis_tuser,   // action, from_aux
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// event_x, event_y, event_button, event_buttons_held, cursor_x, cursor_y,
	// held_buttons, zero fill
	output logic [63:0]                       m_axis_tdata,
	output logic [2:0]                        m_axis_tuser    // event_valid, event_kind
);

	import ps2md_pkg::*;

	logic    cmd_valid;
	cmd_t    cmd;
	logic    cmd_pop;
	result_t res;

	ps2md_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	ps2md_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {7'b0, res.held, res.cur_y, res.cur_x, res.ev_held, res.ev_button,
		res.ev_y, res.ev_x};
	assign m_axis_tuser = {res.ev_kind, res.ev_valid};

	a_move_no_button: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.ev_valid && res.ev_kind == KIND_MOVE |-> res.ev_button == '0)
		else $error("move event carries a button");

	a_button_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.ev_valid && (res.ev_kind == KIND_DOWN || res.ev_kind == KIND_UP)
		|-> $onehot(res.ev_button))
		else $error("button event without one-hot button");

	a_down_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.ev_valid && res.ev_kind == KIND_DOWN
		|-> (res.ev_held & res.ev_button) == res.ev_button)
		else $error("down event for a button not held");

	a_no_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.ev_valid
		|-> res.ev_x == '0 && res.ev_y == '0 && res.ev_button == '0 && res.ev_held == '0)
		else $error("result without event has nonzero event fields");

	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> cmd_valid)
		else $error("front queue refuses a transaction while empty");

endmodule

/* hdl/ps2md_ram.sv */
module ps2md_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/ps2md_front.sv */
module ps2md_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,   // data_byte
	input  logic [1:0]       s_axis_tuser,   // action, from_aux
	output logic             cmd_valid,
	output ps2md_pkg::cmd_t  cmd,
	input  logic             cmd_pop
);

	import ps2md_pkg::*;

	localparam int QP_W = $clog2(CMDQ_DEPTH);
	localparam int QC_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t            q_q [CMDQ_DEPTH];
	logic [QP_W-1:0] wr_q;
	logic [QP_W-1:0] rd_q;
	logic [QC_W-1:0] cnt_q;
	cmd_t            cls;
	logic            push;

	// classify the incoming transaction
	always_comb begin
		cls.data = s_axis_tdata;
		if (s_axis_tuser[0]) begin
			cls.kind = CMD_POLL;
		end else if (s_axis_tuser[1]) begin
			cls.kind = CMD_BYTE;
		end else begin
			cls.kind = CMD_SKIP;
		end
	end

	assign s_axis_tready = (cnt_q != QC_W'(CMDQ_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign cmd_valid     = (cnt_q != '0);
	assign cmd           = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QP_W'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_q <= (rd_q == QP_W'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/ps2md_back.sv */
module ps2md_back #(
	parameter int QUEUE_DEPTH = ps2md_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ps2md_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [ps2md_pkg::SIZE_W-1:0]      cfg_data,
	input  logic                              cmd_valid,
	input  ps2md_pkg::cmd_t                   cmd,
	output logic                              cmd_pop,
	output logic                              res_valid,
	input  logic                              res_ready,
	output ps2md_pkg::result_t                res
);

	import ps2md_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [1:0]        byte_idx_q;
	logic [7:0]        flag_q;
	logic [7:0]        xbyte_q;
	coord_t            pos_x_q;
	coord_t            pos_y_q;
	coord_t            xmax_q;
	coord_t            ymax_q;
	logic [2:0]        btn_q;
	logic [3:0]        pend_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [PTR_W-1:0]  head_nx;
	logic [PTR_W-1:0]  tail_nx;
	result_t           res_q;
	logic              res_valid_q;

	logic signed [8:0]       dx9;
	logic signed [8:0]       dy9;
	logic signed [POS_W-1:0] sum_x;
	logic signed [POS_W-1:0] sum_y;
	coord_t                  new_x;
	coord_t                  new_y;
	logic [2:0]              now_btn;
	logic [2:0]              changed;
	logic                    moved;
	logic                    pkt_done;
	logic                    can_out;
	logic                    empty;
	logic                    full;
	logic [3:0]              low;
	logic [3:0]              pend_rest;
	ev_t                     ev_wr;
	ev_t                     ev_rd;
	logic                    ram_we;
	logic                    ram_re;
	logic                    load_idle;
	logic                    load_poll;

	assign dx9      = {flag_q[4], xbyte_q};
	assign dy9      = {flag_q[5], cmd.data};
	assign sum_x    = $signed({2'b00, pos_x_q}) + POS_W'(dx9);
	assign sum_y    = $signed({2'b00, pos_y_q}) - POS_W'(dy9);
	assign new_x    = clamp_axis(sum_x, xmax_q);
	assign new_y    = clamp_axis(sum_y, ymax_q);
	assign now_btn  = flag_q[2:0];
	assign changed  = now_btn ^ btn_q;
	assign moved    = (dx9 != '0) || (dy9 != '0);
	assign pkt_done = (cmd.kind == CMD_BYTE) && (byte_idx_q == 2'd2) && (flag_q[7:6] == 2'b00);

	assign can_out   = !res_valid_q || res_ready;
	assign head_nx   = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx   = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign empty     = (head_q == tail_q);
	assign full      = (head_nx == tail_q);
	assign low       = pend_q & (~pend_q + 4'd1);
	assign pend_rest = pend_q & ~low;

	// event written this cycle: move first, then buttons from bit 0 up
	always_comb begin
		ev_wr.x    = pos_x_q;
		ev_wr.y    = pos_y_q;
		ev_wr.held = btn_q;
		if (low[0]) begin
			ev_wr.kind   = KIND_MOVE;
			ev_wr.button = '0;
		end else begin
			ev_wr.button = low[3:1];
			ev_wr.kind   = ((btn_q & low[3:1]) != '0) ? KIND_DOWN : KIND_UP;
		end
	end

	ps2md_ram #(
		.WIDTH ($bits(ev_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (ev_wr),
		.re    (ram_re),
		.raddr (tail_q),
		.rdata (ev_rd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && can_out) begin
					if (cmd.kind == CMD_POLL && !empty) begin
						state_d = BK_POLL;
					end else if (pkt_done && (moved || changed != '0)) begin
						state_d = BK_ENQ;
					end
				end
			end
			BK_ENQ: begin
				if (pend_rest == '0) begin
					state_d = BK_IDLE;
				end
			end
			BK_POLL: begin
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		load_idle = 1'b0;
		load_poll = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && can_out) begin
					cmd_pop = 1'b1;
					if (cmd.kind == CMD_POLL && !empty) begin
						ram_re = 1'b1;
					end else begin
						load_idle = 1'b1;
					end
				end
			end
			BK_ENQ: begin
				ram_we = !full;
			end
			BK_POLL: begin
				load_poll = 1'b1;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_idle) begin
			res_q.ev_valid  <= 1'b0;
			res_q.ev_kind   <= KIND_MOVE;
			res_q.ev_x      <= '0;
			res_q.ev_y      <= '0;
			res_q.ev_button <= '0;
			res_q.ev_held   <= '0;
			res_q.cur_x     <= pkt_done ? new_x : pos_x_q;
			res_q.cur_y     <= pkt_done ? new_y : pos_y_q;
			res_q.held      <= pkt_done ? now_btn : btn_q;
		end else if (load_poll) begin
			res_q.ev_valid  <= 1'b1;
			res_q.ev_kind   <= ev_rd.kind;
			res_q.ev_x      <= ev_rd.x;
			res_q.ev_y      <= ev_rd.y;
			res_q.ev_button <= ev_rd.button;
			res_q.ev_held   <= ev_rd.held;
			res_q.cur_x     <= pos_x_q;
			res_q.cur_y     <= pos_y_q;
			res_q.held      <= btn_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			byte_idx_q  <= '0;
			flag_q      <= '0;
			xbyte_q     <= '0;
			pos_x_q     <= axis_centre(SIZE_W'(RESET_WIDTH));
			pos_y_q     <= axis_centre(SIZE_W'(RESET_HEIGHT));
			xmax_q      <= axis_max(SIZE_W'(RESET_WIDTH));
			ymax_q      <= axis_max(SIZE_W'(RESET_HEIGHT));
			btn_q       <= '0;
			pend_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH) begin
					xmax_q  <= axis_max(cfg_data);
					pos_x_q <= axis_centre(cfg_data);
				end else begin
					ymax_q  <= axis_max(cfg_data);
					pos_y_q <= axis_centre(cfg_data);
				end
			end
			if (cmd_pop && cmd.kind == CMD_BYTE) begin
				case (byte_idx_q)
					2'd0: begin
						if (cmd.data[3]) begin
							flag_q     <= cmd.data;
							byte_idx_q <= 2'd1;
						end
					end
					2'd1: begin
						xbyte_q    <= cmd.data;
						byte_idx_q <= 2'd2;
					end
					default: begin
						byte_idx_q <= 2'd0;
					end
				endcase
				if (pkt_done) begin
					pos_x_q <= new_x;
					pos_y_q <= new_y;
					btn_q   <= now_btn;
					pend_q  <= {changed, moved};
				end
			end
			if (state_q == BK_ENQ) begin
				pend_q <= pend_rest;
			end
			if (ram_we) begin
				head_q <= head_nx;
			end
			if (ram_re) begin
				tail_q <= tail_nx;
			end
			if (load_idle || load_poll) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import ps2md_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RING_ROOM = QUEUE_DEPTH_DEF - 1;
	localparam bit ACT_BYTE = 1'b0;
	localparam bit ACT_POLL = 1'b1;
	localparam logic [7:0] FLAG_SYNC = 8'h08;
	localparam logic [7:0] FLAG_OVF = 8'hC0;
	localparam logic [7:0] FLAG_XSIGN = 8'h10;
	localparam logic [7:0] FLAG_YSIGN = 8'h20;
	localparam logic [7:0] FLAG_BTNS = 8'h07;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;   // data_byte
	logic [1:0] s_axis_tuser;   // action, from_aux
	logic m_axis_tvalid;
	logic m_axis_tready;
	// event_x, event_y, event_button, event_buttons_held, cursor_x, cursor_y,
	// held_buttons, zero fill
	logic [63:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;   // event_valid, event_kind

	ps2_mouse_packet_decoder_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// predicted decoder state
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [1:0] pkt_pos;
	logic [7:0] pkt_flags;
	logic [7:0] pkt_dx;
	int cur_x;
	int cur_y;
	logic [2:0] held_q;
	ev_t queued_events[$];
	result_t due_reports[$];

	int errors;
	int cycle_count;
	int hold_off;
	int stall_left;
	bit tx_gaps_on;
	bit rx_stalls_on;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int axis_top(logic [SIZE_W-1:0] size);
		int m;
		m = (size == 0) ? 0 : int'(size) - 1;
		return (m > int'(COORD_MAX)) ? int'(COORD_MAX) : m;
	endfunction

	function automatic int axis_mid(logic [SIZE_W-1:0] size);
		int c;
		int m;
		c = int'(size) / 2;
		m = axis_top(size);
		return (c > m) ? m : c;
	endfunction

	function automatic int fit_axis(int v, int m);
		if (v < 0) begin
			return 0;
		end
		return (v > m) ? m : v;
	endfunction

	function automatic void log_event(ev_kind_t kind, logic [2:0] button);
		ev_t e;
		if (queued_events.size() >= RING_ROOM) begin
			return;
		end
		e.kind = kind;
		e.x = cur_x[COORD_BITS-1:0];
		e.y = cur_y[COORD_BITS-1:0];
		e.button = button;
		e.held = held_q;
		queued_events.push_back(e);
	endfunction

	function automatic void absorb_byte(logic [7:0] b);
		int dx;
		int dy;
		logic [2:0] now;
		logic [2:0] changed;
		case (pkt_pos)
			2'd0: begin
				if ((b & FLAG_SYNC) != 0) begin
					pkt_flags = b;
					pkt_pos = 2'd1;
				end
			end
			2'd1: begin
				pkt_dx = b;
				pkt_pos = 2'd2;
			end
			default: begin
				pkt_pos = 2'd0;
				if ((pkt_flags & FLAG_OVF) == 0) begin
					dx = int'(pkt_dx) - (((pkt_flags & FLAG_XSIGN) != 0) ? 256 : 0);
					dy = int'(b) - (((pkt_flags & FLAG_YSIGN) != 0) ? 256 : 0);
					cur_x = fit_axis(cur_x + dx, axis_top(width_q));
					cur_y = fit_axis(cur_y - dy, axis_top(height_q));
					now = pkt_flags[2:0];
					changed = now ^ held_q;
					held_q = now;
					if (dx != 0 || dy != 0) begin
						log_event(KIND_MOVE, 3'b000);
					end
					for (int i = 0; i < 3; i++) begin
						if (changed[i]) begin
							log_event(now[i] ? KIND_DOWN : KIND_UP, 3'b001 << i);
						end
					end
				end
			end
		endcase
	endfunction

	function automatic result_t decode_item(bit action, logic [7:0] b, bit aux);
		result_t r;
		ev_t e;
		r = '0;
		if (action == ACT_BYTE) begin
			if (aux) begin
				absorb_byte(b);
			end
		end else if (queued_events.size() != 0) begin
			e = queued_events.pop_front();
			r.ev_valid = 1'b1;
			r.ev_kind = e.kind;
			r.ev_x = e.x;
			r.ev_y = e.y;
			r.ev_button = e.button;
			r.ev_held = e.held;
		end
		r.cur_x = cur_x[COORD_BITS-1:0];
		r.cur_y = cur_y[COORD_BITS-1:0];
		r.held = held_q;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 8);
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		if (errors <= 40) begin
			$display("tb_top: %s mismatch at %0t, got %0h want %0h", what, $realtime, got, want);
		end
	endtask

	task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
		if (got !== want) begin
			report(what, got, want);
		end
	endtask

	task automatic check_result();
		result_t want;
		if (due_reports.size() == 0) begin
			report("unexpected transaction", m_axis_tdata, '0);
			return;
		end
		want = due_reports.pop_front();
		check_field("event_valid", m_axis_tuser[0], want.ev_valid);
		check_field("event_kind", m_axis_tuser[2:1], want.ev_kind);
		check_field("event_x", m_axis_tdata[11:0], want.ev_x);
		check_field("event_y", m_axis_tdata[23:12], want.ev_y);
		check_field("event_button", m_axis_tdata[26:24], want.ev_button);
		check_field("event_buttons_held", m_axis_tdata[29:27], want.ev_held);
		check_field("cursor_x", m_axis_tdata[41:30], want.cur_x);
		check_field("cursor_y", m_axis_tdata[53:42], want.cur_y);
		check_field("held_buttons", m_axis_tdata[56:54], want.held);
		check_field("zero fill", m_axis_tdata[63:57], '0);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			check_result();
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// receiver: hold-off window first, then random stalls while rx_stalls_on is set
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_axis_tready <= 1'b0;
				hold_off--;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (rx_stalls_on) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	task automatic send_item(bit action, logic [7:0] b, bit aux);
		int gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= {aux, action};
		do @(posedge clk); while (!s_axis_tready);
		due_reports.push_back(decode_item(action, b, aux));
	endtask

	task automatic send_poll();
		send_item(ACT_POLL, 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic send_packet(logic [7:0] flags, logic [7:0] dx, logic [7:0] dy);
		send_item(ACT_BYTE, flags, 1'b1);
		send_item(ACT_BYTE, dx, 1'b1);
		send_item(ACT_BYTE, dy, 1'b1);
	endtask

	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (due_reports.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH) begin
			width_q = value;
			cur_x = axis_mid(value);
		end else begin
			height_q = value;
			cur_y = axis_mid(value);
		end
	endtask

	task automatic test_basic_decode();
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		send_item(ACT_POLL, 8'hFF, 1'b1);
		// non-aux byte with sync bit set must not start a packet
		send_item(ACT_BYTE, 8'h0F, 1'b0);
		send_packet(8'h09, 8'h05, 8'h03);
		// bytes without sync bit are dropped
		send_item(ACT_BYTE, 8'h00, 1'b1);
		send_item(ACT_BYTE, 8'hF7, 1'b1);
		send_packet(8'h08, 8'h00, 8'h00);
		send_packet(8'h4F, 8'h10, 8'h10);
		send_packet(8'h8F, 8'h10, 8'h10);
		send_packet(8'h18, 8'h00, 8'h00);
		send_packet(8'h2F, 8'hFF, 8'h00);
		send_packet(8'h3E, 8'hFF, 8'hFF);
		repeat (4) send_poll();
		settle();
	endtask

	task automatic test_screen_sizes();
		logic [SIZE_W-1:0] sizes[6];
		sizes = '{13'd0, 13'd1, 13'd2, 13'd4096, 13'h1FFF, 13'd4095};
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b1;
		foreach (sizes[i]) begin
			write_reg(REG_WIDTH, sizes[i]);
			write_reg(REG_HEIGHT, sizes[(i + 3) % 6]);
			send_packet(8'h08, 8'hFF, 8'hFF);
			send_packet(8'h38, 8'h00, 8'h00);
			send_packet(8'h08, 8'h7F, 8'h80);
			repeat (2) send_poll();
			settle();
		end
		write_reg(REG_WIDTH, 13'(RESET_WIDTH));
		write_reg(REG_HEIGHT, 13'(RESET_HEIGHT));
	endtask

	task automatic test_ring_overflow();
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		repeat (queued_events.size()) send_poll();
		for (int i = 0; i < 9; i++) begin
			send_packet((i % 2 == 0) ? 8'h0F : 8'h08, 8'h01, 8'h00);
		end
		repeat (RING_ROOM + 2) send_poll();
		settle();
	endtask

	task automatic test_output_backpressure();
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		hold_off = 300;
		for (int i = 0; i < 10; i++) begin
			send_packet(8'($urandom_range(255)) & ~FLAG_OVF | FLAG_SYNC,
				8'($urandom_range(255)), 8'($urandom_range(255)));
			send_poll();
		end
		settle();
	endtask

	task automatic run_random_phase(int quota);
		int sent;
		int r;
		logic [7:0] flags;
		logic [7:0] bytes[3];
		sent = 0;
		while (sent < quota) begin
			r = $urandom_range(99);
			if (r < 60) begin
				flags = 8'($urandom_range(255)) | FLAG_SYNC;
				if ($urandom_range(99) < 85) begin
					flags = flags & ~FLAG_OVF;
				end
				if ($urandom_range(99) < 20) begin
					flags = (flags & ~FLAG_BTNS) | (held_q & FLAG_BTNS);
				end
				bytes = '{flags, 8'($urandom_range(255)), 8'($urandom_range(255))};
				foreach (bytes[i]) begin
					send_item(ACT_BYTE, bytes[i], 1'b1);
					if ($urandom_range(9) == 0) begin
						send_poll();
						sent++;
					end else if ($urandom_range(19) == 0) begin
						send_item(ACT_BYTE, 8'($urandom_range(255)), 1'b0);
						sent++;
					end
				end
				sent += 3;
			end else if (r < 85) begin
				repeat ($urandom_range(3, 1)) begin
					send_poll();
					sent++;
				end
			end else if (r < 93) begin
				send_item(ACT_BYTE, 8'($urandom_range(255)), 1'b0);
				sent++;
			end else begin
				send_item(ACT_BYTE, 8'($urandom_range(255)), 1'b1);
				sent++;
			end
		end
		settle();
	endtask

	task automatic test_random_traffic();
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		run_random_phase(50);
		write_reg(REG_WIDTH, 13'($urandom_range(4096, 1)));
		write_reg(REG_HEIGHT, 13'($urandom_range(4096, 1)));
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		run_random_phase(50);
		write_reg(REG_WIDTH, 13'($urandom_range(8, 1)));
		write_reg(REG_HEIGHT, 13'($urandom_range(8, 1)));
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b0;
		run_random_phase(50);
		write_reg(REG_WIDTH, 13'($urandom_range(4096, 1)));
		write_reg(REG_HEIGHT, 13'($urandom_range(4096, 1)));
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b1;
		run_random_phase(50);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		errors = 0;
		cycle_count = 0;
		hold_off = 0;
		stall_left = 0;
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		width_q = 13'(RESET_WIDTH);
		height_q = 13'(RESET_HEIGHT);
		pkt_pos = '0;
		pkt_flags = '0;
		pkt_dx = '0;
		cur_x = axis_mid(width_q);
		cur_y = axis_mid(height_q);
		held_q = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_decode();
		test_screen_sizes();
		test_ring_overflow();
		test_output_backpressure();
		test_random_traffic();

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/ps2md_pkg.sv
hdl/ps2md_ram.sv
hdl/ps2md_front.sv
hdl/ps2md_back.sv
hdl/ps2md_top.sv
verif/tb_top.sv
